@@ rtl/core/pbtp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbtp_pkg: shared types and constants
// Transaction payloads, configuration set and queue entry for the packed
// bitmap to points block.
// ----------------------------------------------------------------------------
package pbtp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // register index codes of the csr port
   typedef enum logic [2:0] {
      CSR_PIXEL_DEPTH = 3'd0,
      CSR_GLYPH_WIDTH = 3'd1,
      CSR_GLYPH_HEIGHT = 3'd2,
      CSR_ORIGIN_X = 3'd3,
      CSR_ORIGIN_Y = 3'd4
   } pbtp_csr_index_type;

   // pixel depth codes
   typedef enum logic [1:0] {
      DEPTH_1BPP = 2'd0,
      DEPTH_2BPP = 2'd1,
      DEPTH_4BPP = 2'd2,
      DEPTH_8BPP = 2'd3
   } pbtp_depth_type;

   typedef struct packed {
      logic [7:0] bitmap_byte;
      logic       glyph_start;
   } pbtp_req_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last_of_byte;
   } pbtp_rsp_type;

   typedef struct packed {
      pbtp_depth_type     pixel_depth;
      logic [7:0]         glyph_width;
      logic [7:0]         glyph_height;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } pbtp_cfg_type;

   // one byte's work: pixels to emit (bit k = column k of the byte),
   // x of the byte's first column, y of its row
   typedef struct packed {
      logic [7:0]  pixel_mask;
      logic [15:0] base_x;
      logic [15:0] row_y;
   } pbtp_entry_type;

endpackage
`default_nettype wire

@@ rtl/core/pbtp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbtp_front: byte classifier
// Tracks row and byte-in-row, picks the pixels of a byte that give points
// and pushes one queue entry per byte that gives at least one point.
// ----------------------------------------------------------------------------
module pbtp_front
   import pbtp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pbtp_cfg_type   cfg,
   input  wire logic           req_valid,
   input  wire pbtp_req_type   req_payload,
   input  wire logic           queue_full,
   output logic                push,
   output pbtp_entry_type      push_entry
);

   logic [7:0]  row_ff, row_in;
   logic [7:0]  bir_ff, bir_in;
   logic        accept;
   logic [7:0]  row_cur, bir_cur, bir_inc;
   logic [10:0] row_bits;
   logic [7:0]  bytes_per_row;
   logic        in_glyph;
   logic [10:0] base_col;
   logic [7:0]  nz_1, nz_2, nz_4, nz_8, nz_sel;
   logic [7:0]  col_ok;
   logic [7:0]  data;

   assign accept = req_valid && !queue_full;
   assign data   = req_payload.bitmap_byte;

   always_comb begin
      row_cur = req_payload.glyph_start ? 8'd0 : row_ff;
      bir_cur = req_payload.glyph_start ? 8'd0 : bir_ff;
      // up to 255 pixels of 8 bits: 2040 bits per row
      row_bits = 11'(cfg.glyph_width) << cfg.pixel_depth;
      bytes_per_row = 8'((row_bits + 11'd7) >> 3);
      in_glyph = (bytes_per_row != 8'd0) && (row_cur < cfg.glyph_height);
      base_col = 11'(bir_cur) << (2'd3 - cfg.pixel_depth);
   end

   // nonzero pixels per depth, bit k is the k-th pixel from the MSB
   always_comb begin
      nz_1 = '0;
      nz_2 = '0;
      nz_4 = '0;
      nz_8 = '0;
      for (int j = 0; j < 8; j++) begin
         nz_1[j] = data[7 - j];
      end
      for (int j = 0; j < 4; j++) begin
         nz_2[j] = |data[7 - 2 * j -: 2];
      end
      for (int j = 0; j < 2; j++) begin
         nz_4[j] = |data[7 - 4 * j -: 4];
      end
      nz_8[0] = |data;
      case (cfg.pixel_depth)
         DEPTH_1BPP: nz_sel = nz_1;
         DEPTH_2BPP: nz_sel = nz_2;
         DEPTH_4BPP: nz_sel = nz_4;
         default:    nz_sel = nz_8;
      endcase
      for (int k = 0; k < 8; k++) begin
         col_ok[k] = (base_col + 11'(k)) < 11'(cfg.glyph_width);
      end
   end

   always_comb begin
      bir_inc = bir_cur + 8'd1;
      row_in  = row_cur;
      bir_in  = bir_cur;
      if (in_glyph) begin
         if (bir_inc >= bytes_per_row || bir_inc == 8'd0) begin
            bir_in = 8'd0;
            row_in = row_cur + 8'd1;
         end else begin
            bir_in = bir_inc;
         end
      end
   end

   always_comb begin
      push_entry.pixel_mask = nz_sel & col_ok;
      push_entry.base_x     = cfg.origin_x + 16'(base_col);
      push_entry.row_y      = cfg.origin_y + 16'(row_cur);
      push = accept && in_glyph && (push_entry.pixel_mask != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         bir_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         bir_ff <= bir_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/pbtp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbtp_queue: entry queue
// Small FIFO that decouples the classifier from the point emitter.
// ----------------------------------------------------------------------------
module pbtp_queue
   import pbtp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire pbtp_entry_type push_entry,
   input  wire logic           pop,
   output logic                full,
   output logic                not_empty,
   output pbtp_entry_type      head_entry
);

   pbtp_entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]       count_ff, count_in;
   logic                       do_pop;

   assign full       = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/pbtp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbtp_back: point emitter
// Walks the pixel mask of one entry lowest column first, one point per
// cycle while rsp does not stall, into the output register.
// ----------------------------------------------------------------------------
module pbtp_back
   import pbtp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           queue_not_empty,
   input  wire pbtp_entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   output pbtp_rsp_type        rsp_payload,
   input  wire logic           rsp_stall
);

   logic           cur_valid_ff, cur_valid_in;
   pbtp_entry_type cur_ff, cur_in;
   logic           out_valid_ff, out_valid_in;
   pbtp_rsp_type   out_ff, out_in;
   logic           out_free, emit;
   logic [2:0]     first_k;
   logic [7:0]     mask_left;
   logic           last;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;

   // lowest set bit = leftmost remaining column
   always_comb begin
      first_k = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (cur_ff.pixel_mask[k]) begin
            first_k = 3'(k);
         end
      end
      mask_left = cur_ff.pixel_mask & ~(8'd1 << first_k);
      last      = (mask_left == 8'd0);
   end

   always_comb begin
      pop          = (!cur_valid_ff || (emit && last)) && queue_not_empty;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = head_entry;
      end else if (emit) begin
         cur_valid_in          = !last;
         cur_in.pixel_mask     = mask_left;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in        = 1'b1;
         out_in.point_x      = cur_ff.base_x + 16'(first_k);
         out_in.point_y      = cur_ff.row_y;
         out_in.last_of_byte = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

@@ rtl/core/packed_bitmap_to_points_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// packed_bitmap_to_points_top: glyph bitmap unpacker
// Turns packed glyph bitmap bytes into a stream of set-pixel points.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one bitmap byte per transaction (valid/stall), row-major,
//    rows padded to whole bytes; glyph_start marks a glyph's first byte and
//    restarts the row and byte counters.
//  - rsp channel: one point per transaction (valid/stall), in column order;
//    last_of_byte flags the final point of a byte. Bytes with no set pixel
//    inside the glyph, padding and bytes past the glyph height give none.
//  - csr port: plain writes (csr_we, csr_index, csr_wdata); write only while
//    the block is idle.
// Timing:
//  - the classifier takes one byte per cycle while its 4-entry queue has
//    room; the emitter gives one point per cycle while rsp is not stalled,
//    up to 8 points per byte at 1 bit per pixel.
//  - a byte's points pass the queue, then the entry and output registers.
// Reset: counters, queue and output register clear; registers go to zero.
// A stalled rsp holds its point; the queue fills and req_stall rises.
// ----------------------------------------------------------------------------
module packed_bitmap_to_points_top
   import pbtp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire pbtp_req_type req_payload,
   output logic              req_stall,
   output logic              rsp_valid,
   output pbtp_rsp_type      rsp_payload,
   input  wire logic         rsp_stall,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   pbtp_cfg_type   cfg_ff, cfg_in;
   logic           push, pop, queue_full, queue_not_empty;
   pbtp_entry_type push_entry, head_entry;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PIXEL_DEPTH:  cfg_in.pixel_depth  = pbtp_depth_type'(csr_wdata[1:0]);
            CSR_GLYPH_WIDTH:  cfg_in.glyph_width  = csr_wdata[7:0];
            CSR_GLYPH_HEIGHT: cfg_in.glyph_height = csr_wdata[7:0];
            CSR_ORIGIN_X:     cfg_in.origin_x     = csr_wdata;
            CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall on a full queue; derived from registered count only
   assign req_stall = queue_full;

   pbtp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   pbtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   pbtp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_payload     (rsp_payload),
      .rsp_stall       (rsp_stall)
   );

endmodule
`default_nettype wire

@@ rtl/core/pbtp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbtp_checker: port-level checks
// Reset behavior and rsp handshake rules seen at the top level's ports.
// ----------------------------------------------------------------------------
module pbtp_checker
   import pbtp_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire pbtp_rsp_type rsp_payload,
   input wire logic         rsp_stall
);

   // nothing is pending right after reset
   a_reset_rsp_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // queue is empty after reset, so input is open
   a_reset_req_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req_stall high after reset");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("rsp_payload changed while stalled");

endmodule

bind packed_bitmap_to_points_top pbtp_checker u_pbtp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload),
   .rsp_stall   (rsp_stall)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for packed_bitmap_to_points_top
// Drives glyph bitmap bytes through the req channel and predicts every
// emitted point with a local model of the row and byte counters. Each rsp
// transaction is checked field by field against the oldest predicted point.
// The sender works in random bursts, the receiver stalls on its own pattern,
// and one test holds rsp off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import pbtp_pkg::*;

   localparam int SETTLE_CYCLES  = 16;   // covers bytes that give no point
   localparam int HOLD_CYCLES    = 200;  // long rsp hold-off in the pressure test
   localparam int WATCHDOG_LIMIT = 1000; // well above the hold-off
   localparam int RANDOM_BYTES   = 40;   // in-glyph bytes in the random test

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   // DUT connections; every input starts at a known value
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   pbtp_req_type req_payload = '0;
   logic         req_stall;
   logic         rsp_valid;
   pbtp_rsp_type rsp_payload;
   logic         rsp_stall = 1'b0;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = CSR_PIXEL_DEPTH;
   logic [15:0]  csr_wdata = '0;

   // glyph model: register copy, counters and the points still owed
   pbtp_cfg_type glyph_cfg = '0;
   logic [7:0]   glyph_row = '0;
   logic [7:0]   row_byte = '0;
   pbtp_rsp_type expected_points[$];
   pbtp_rsp_type oldest_point;

   int             mismatch_count = 0;
   int             glyph_bytes = 0;   // bytes that landed inside a glyph
   int             burst_left = 0;
   int             quiet_cycles = 0;
   bit             hold_request = 1'b0;
   int             hold_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;

   packed_bitmap_to_points_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Model of one accepted byte. Pushes the points it gives, in column
   // order, and returns 1 when the byte lies inside the glyph (counters move).
   // ------------------------------------------------------------------------
   function automatic bit predict_points(input pbtp_req_type item);
      int unsigned  bpp;
      int unsigned  per_byte;
      int unsigned  bytes_per_row;
      int unsigned  col;
      int unsigned  pix;
      int unsigned  k;
      int           count;
      pbtp_rsp_type pts [8];
      bpp = 1 << glyph_cfg.pixel_depth;
      per_byte = 8 / bpp;
      bytes_per_row = (glyph_cfg.glyph_width * bpp + 7) >> 3;
      count = 0;
      if (item.glyph_start) begin
         glyph_row = '0;
         row_byte = '0;
      end
      // zero-width glyph or a byte past the last row: nothing, counters hold
      if (bytes_per_row == 0 || glyph_row >= glyph_cfg.glyph_height) return 1'b0;
      for (k = 0; k < per_byte; k++) begin
         col = row_byte * per_byte + k;
         pix = (item.bitmap_byte >> (8 - (k + 1) * bpp)) & ((1 << bpp) - 1);
         // pixels at or past the width are row padding
         if (col < glyph_cfg.glyph_width && pix != 0) begin
            pts[count].point_x = glyph_cfg.origin_x + col[15:0];
            pts[count].point_y = glyph_cfg.origin_y + {8'h00, glyph_row};
            pts[count].last_of_byte = 1'b0;
            count++;
         end
      end
      if (count > 0) pts[count - 1].last_of_byte = 1'b1;
      for (k = 0; k < count; k++) expected_points.push_back(pts[k]);
      row_byte = row_byte + 8'd1;
      if (row_byte >= bytes_per_row || row_byte == 8'd0) begin
         row_byte = '0;
         glyph_row = glyph_row + 8'd1;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Sender: one req transaction. Valid is left high after acceptance so the
   // next byte can follow back to back; wait_idle lowers it.
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] data, input bit start);
      int           gap;
      pbtp_req_type item;
      item.bitmap_byte = data;
      item.glyph_start = start;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         // a third of the bursts run straight on from the previous one
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      if (predict_points(item)) glyph_bytes++;
   endtask

   // Block is idle once every point is out and a trailing empty byte had time
   // to pass through.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input pbtp_csr_index_type idx, input logic [15:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PIXEL_DEPTH: glyph_cfg.pixel_depth = pbtp_depth_type'(value[1:0]);
         CSR_GLYPH_WIDTH: glyph_cfg.glyph_width = value[7:0];
         CSR_GLYPH_HEIGHT: glyph_cfg.glyph_height = value[7:0];
         CSR_ORIGIN_X: glyph_cfg.origin_x = value;
         CSR_ORIGIN_Y: glyph_cfg.origin_y = value;
         default: ;
      endcase
   endtask

   task automatic configure(input pbtp_depth_type depth, input logic [7:0] width,
                            input logic [7:0] height, input logic [15:0] ox,
                            input logic [15:0] oy);
      set_reg(CSR_PIXEL_DEPTH, {14'd0, depth});
      set_reg(CSR_GLYPH_WIDTH, {8'd0, width});
      set_reg(CSR_GLYPH_HEIGHT, {8'd0, height});
      set_reg(CSR_ORIGIN_X, ox);
      set_reg(CSR_ORIGIN_Y, oy);
   endtask

   // ------------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------------

   // registers at reset give a zero-width glyph: a full byte emits nothing
   task automatic test_reset_state();
      send_byte(8'hFF, 1'b1);
   endtask

   // 10-wide, 2-row glyph at 1 bpp: padding bits, past-the-glyph bytes,
   // restart, and x/y wrap from the positive extreme
   task automatic test_padding_and_wrap();
      configure(DEPTH_1BPP, 8'd10, 8'd2, 16'h7FFF, 16'h7FFF);
      send_byte(8'hFF, 1'b1);   // row 0 cols 0..7, x wraps after col 0
      send_byte(8'h3F, 1'b0);   // only padding bits set: empty, counters move
      send_byte(8'h81, 1'b0);   // row 1, y wraps
      send_byte(8'hFF, 1'b0);   // cols 8, 9 only
      send_byte(8'hFF, 1'b0);   // past the last row
      send_byte(8'h00, 1'b1);   // restart with an empty byte
   endtask

   // every pixel depth, pixel values from low to high, negative origins
   task automatic test_pixel_depths();
      configure(DEPTH_1BPP, 8'd5, 8'd1, 16'h8000, 16'hFFFF);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      configure(DEPTH_2BPP, 8'd5, 8'd1, 16'h8000, 16'hFFFF);
      send_byte(8'h1B, 1'b1);   // pixel values 0, 1, 2, 3
      send_byte(8'hFF, 1'b0);   // col 4, then padding
      configure(DEPTH_4BPP, 8'd5, 8'd1, 16'h8000, 16'hFFFF);
      send_byte(8'h0F, 1'b1);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h18, 1'b0);
      configure(DEPTH_8BPP, 8'd5, 8'd1, 16'h8000, 16'hFFFF);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
   endtask

   // new width and origin mid-glyph: counters carry on, new values apply
   task automatic test_mid_glyph_change();
      configure(DEPTH_1BPP, 8'd16, 8'd3, 16'd100, 16'd200);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      set_reg(CSR_ORIGIN_X, 16'hFFFB);
      set_reg(CSR_GLYPH_WIDTH, 16'd4);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   // widest and tallest glyph, then a zero-height one
   task automatic test_size_extremes();
      configure(DEPTH_8BPP, 8'd255, 8'd255, 16'h7FFF, 16'h8000);
      send_byte(8'hFE, 1'b1);
      set_reg(CSR_GLYPH_HEIGHT, 16'd0);
      send_byte(8'hFF, 1'b1);
   endtask

   // rsp held off while bytes keep coming: queue fills and req stalls
   task automatic test_rsp_holdoff();
      int i;
      configure(DEPTH_1BPP, 8'd8, 8'd255, 16'($urandom), 16'($urandom));
      hold_request = 1'b1;
      for (i = 0; i < 40; i++) begin
         send_byte((i % 3 == 0) ? 8'($urandom) : 8'hFF, i == 0);
      end
      wait_idle();
   endtask

   // random settings; mostly well-formed glyphs, some cut short, overrun
   // or with stray glyph_start bits
   task automatic test_random_glyphs();
      pbtp_depth_type depth;
      logic [7:0]     width;
      logic [7:0]     height;
      logic [15:0]    ox;
      logic [15:0]    oy;
      int             per_byte;
      int             glyph_len;
      int             style;
      int             g;
      int             i;
      logic [7:0]     data;
      bit             start;
      glyph_bytes = 0;
      while (glyph_bytes < RANDOM_BYTES) begin
         depth = pbtp_depth_type'($urandom_range(0, 3));
         per_byte = 8 >> depth;
         case ($urandom_range(0, 9))
            0: width = 8'd0;
            1: width = 8'd255;
            default: width = 8'($urandom_range(1, 3 * per_byte));
         endcase
         height = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
         ox = ($urandom_range(0, 3) == 0) ? 16'h7FFF - 16'($urandom_range(0, 8))
                                          : 16'($urandom);
         oy = ($urandom_range(0, 3) == 0) ? 16'h7FFF - 16'($urandom_range(0, 3))
                                          : 16'($urandom);
         configure(depth, width, height, ox, oy);
         for (g = 0; g < $urandom_range(2, 4); g++) begin
            glyph_len = ((width * (1 << depth) + 7) >> 3) * height;
            if (glyph_len == 0 || glyph_len > 64) glyph_len = $urandom_range(1, 8);
            style = $urandom_range(0, 9);
            if (style == 7) glyph_len = $urandom_range(1, glyph_len);
            else if (style == 8) glyph_len = glyph_len + $urandom_range(1, 4);
            for (i = 0; i < glyph_len; i++) begin
               case ($urandom_range(0, 5))
                  0: data = 8'h01 << $urandom_range(0, 7);
                  1: data = 8'h00;
                  2: data = 8'hFF;
                  default: data = 8'($urandom);
               endcase
               start = (style == 9) ? ($urandom_range(0, 3) == 0) : (i == 0);
               send_byte(data, start);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: stall pattern changes at random among four modes, including quiet
   // stretches; a hold request from the pressure test overrides it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Checker: every accepted point against the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report_mismatch("point with none expected, x", rsp_payload.point_x, 16'h0000);
         end else begin
            oldest_point = expected_points.pop_front();
            if (rsp_payload.point_x !== oldest_point.point_x)
               report_mismatch("point_x", rsp_payload.point_x, oldest_point.point_x);
            if (rsp_payload.point_y !== oldest_point.point_y)
               report_mismatch("point_y", rsp_payload.point_y, oldest_point.point_y);
            if (rsp_payload.last_of_byte !== oldest_point.last_of_byte)
               report_mismatch("last_of_byte", {15'd0, rsp_payload.last_of_byte},
                               {15'd0, oldest_point.last_of_byte});
         end
      end
   end

   // Watchdog: too long without any transaction or register write
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("packed_bitmap_to_points_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_padding_and_wrap();
      test_pixel_depths();
      test_mid_glyph_change();
      test_size_extremes();
      test_rsp_holdoff();
      test_random_glyphs();
      wait_idle();
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("packed_bitmap_to_points_top regression: pass");
      end else begin
         $display("packed_bitmap_to_points_top regression: fail");
      end
      $finish;
   end

endmodule

@@ packed_bitmap_to_points_top.f @@
rtl/core/pbtp_pkg.sv
rtl/core/pbtp_front.sv
rtl/core/pbtp_queue.sv
rtl/core/pbtp_back.sv
rtl/core/packed_bitmap_to_points_top.sv
rtl/core/pbtp_checker.sv
tb/tb_top.sv
